### rtl/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned FracBitsMax = 16;
  localparam int unsigned QuoWidth = 32 + FracBitsMax;

  localparam logic signed [31:0] Max32 = 32'sh7fffffff;
  localparam logic signed [31:0] Min32 = 32'sh80000000;

  typedef enum logic [3:0] {
    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_GT, FN_LT, FN_GE, FN_LE,
    FN_EQ, FN_NE, FN_INC, FN_DEC, FN_MIN, FN_MAX, FN_TOINT, FN_FROMINT
  } func_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               flag;
    logic               overflow;
    logic               div_zero;
  } out_word_t;

  typedef struct packed {
    func_t                 func;
    logic signed [31:0]    res;
    logic                  flag;
    logic                  ovf;
    logic                  dz;
    logic                  neg;
    logic [63:0]           prod;
    logic [QuoWidth-1:0]   num;
    logic [31:0]           den;
    logic [31:0]           rem;
    logic [QuoWidth-1:0]   quo;
  } work_t;

  function automatic logic [32:0] sat33(input logic [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = {1'b1, (v[32] ? Min32 : Max32)};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/fpa_entry.sv
`default_nettype none
module fpa_entry #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire fpa_pkg::in_word_t in_data,
  input  wire logic             down_open,
  output logic                  open,
  output logic                  valid,
  output fpa_pkg::work_t        data
);
  import fpa_pkg::*;

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [31:0]        ma;
  logic [31:0]        mb;
  logic [32:0]        sat;
  logic signed [63:0] wide;
  work_t              w;

  assign open = !valid || down_open;

  always_comb begin
    a = in_data.operand_a;
    b = in_data.operand_b;
    ma = a[31] ? (~a + 32'd1) : a;
    mb = b[31] ? (~b + 32'd1) : b;
    sat = '0;
    wide = 64'(a) <<< FRAC_BITS;
    w = '0;
    w.func = in_data.func;
    w.neg = a[31] ^ b[31];
    w.den = mb;
    w.num = QuoWidth'(ma) << FRAC_BITS;
    w.prod = 64'(ma) * 64'(mb);
    case (in_data.func)
      FN_ADD: begin
        sat = sat33({a[31], a} + {b[31], b});
        w.res = sat[31:0];
        w.ovf = sat[32];
      end
      FN_SUB: begin
        sat = sat33({a[31], a} - {b[31], b});
        w.res = sat[31:0];
        w.ovf = sat[32];
      end
      FN_DIV: begin
        if (b == 32'sd0) begin
          w.dz = 1'b1;
          w.res = a[31] ? Min32 : ((a == 32'sd0) ? 32'sd0 : Max32);
        end
      end
      FN_GT: w.flag = a > b;
      FN_LT: w.flag = a < b;
      FN_GE: w.flag = a >= b;
      FN_LE: w.flag = a <= b;
      FN_EQ: w.flag = a == b;
      FN_NE: w.flag = a != b;
      FN_INC: begin
        sat = sat33({a[31], a} + 33'sd1);
        w.res = sat[31:0];
        w.ovf = sat[32];
      end
      FN_DEC: begin
        sat = sat33({a[31], a} - 33'sd1);
        w.res = sat[31:0];
        w.ovf = sat[32];
      end
      FN_MIN: w.res = (a < b) ? a : b;
      FN_MAX: w.res = (a > b) ? a : b;
      FN_TOINT: w.res = a >>> FRAC_BITS;
      FN_FROMINT: begin
        if (wide > 64'(Max32)) begin
          w.res = Max32;
          w.ovf = 1'b1;
        end else if (wide < 64'(Min32)) begin
          w.res = Min32;
          w.ovf = 1'b1;
        end else begin
          w.res = wide[31:0];
        end
      end
      default: w.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (open) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (open && in_valid) begin
      data <= w;
    end
  end
endmodule
`default_nettype wire

### rtl/fpa_cell.sv
`default_nettype none
module fpa_cell #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           up_valid,
  input  wire fpa_pkg::work_t up_data,
  input  wire logic           down_open,
  output logic                open,
  output logic                valid,
  output fpa_pkg::work_t      data
);
  import fpa_pkg::*;

  localparam int unsigned NumBits = 32 + FRAC_BITS;

  logic [32:0] r2;
  logic [32:0] diff;
  logic        ge;
  work_t       w;

  assign open = !valid || down_open;

  always_comb begin
    r2 = {up_data.rem, up_data.num[NumBits-1]};
    diff = r2 - {1'b0, up_data.den};
    ge = r2 >= {1'b0, up_data.den};
    w = up_data;
    w.rem = ge ? diff[31:0] : r2[31:0];
    w.num = up_data.num << 1;
    w.quo = {up_data.quo[QuoWidth-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (open) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (open && up_valid) begin
      data <= w;
    end
  end
endmodule
`default_nettype wire

### rtl/fpa_round.sv
`default_nettype none
module fpa_round #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           up_valid,
  input  wire fpa_pkg::work_t up_data,
  input  wire logic           out_stall,
  output logic                open,
  output logic                out_valid,
  output fpa_pkg::out_word_t  out_data
);
  import fpa_pkg::*;

  logic [63:0] m;
  logic        inc;
  logic [63:0] q;
  out_word_t   o;

  assign open = !out_valid || !out_stall;

  always_comb begin
    m = '0;
    inc = 1'b0;
    if (up_data.func == FN_MUL) begin
      m = up_data.prod >> FRAC_BITS;
      inc = up_data.prod[FRAC_BITS-1];
    end else begin
      m = 64'(up_data.quo);
      inc = {up_data.rem, 1'b0} >= {1'b0, up_data.den};
    end
    q = m + 64'(inc);
    o.result = up_data.res;
    o.flag = up_data.flag;
    o.overflow = up_data.ovf;
    o.div_zero = up_data.dz;
    if (up_data.func == FN_MUL || (up_data.func == FN_DIV && !up_data.dz)) begin
      if (up_data.neg) begin
        if (q > 64'h8000_0000) begin
          o.result = Min32;
          o.overflow = 1'b1;
        end else begin
          o.result = 32'(~q + 64'd1);
        end
      end else begin
        if (q > 64'h7fff_ffff) begin
          o.result = Max32;
          o.overflow = 1'b1;
        end else begin
          o.result = q[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (open) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (open && up_valid) begin
      out_data <= o;
    end
  end
endmodule
`default_nettype wire

### rtl/fixed_point_alu.sv
`default_nettype none
// Signed fixed-point ALU with FRAC_BITS fraction bits. A new word is taken in every cycle
// while in_stall is low, and each word yields one result word; the pipeline depth is set by
// the division chain, a row of 32 + FRAC_BITS cells that each produce one quotient bit, with
// one entry stage ahead of it and one rounding and saturation stage after it.
// Every stage holds its word while the next is full and held, so bubbles close up under stall.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fpa_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fpa_pkg::out_word_t      out_data
);
  import fpa_pkg::*;

  localparam int unsigned NumCells = 32 + FRAC_BITS;

  logic  v [0:NumCells];
  work_t w [0:NumCells];
  logic  op [0:NumCells];
  logic  entry_open;

  assign in_stall = !entry_open;

  fpa_entry #(.FRAC_BITS(FRAC_BITS)) u_entry (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_data(in_data),
    .down_open(op[0]), .open(entry_open), .valid(v[0]), .data(w[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fpa_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk), .rst(rst), .up_valid(v[i]), .up_data(w[i]),
      .down_open(op[i+1]), .open(op[i]), .valid(v[i+1]), .data(w[i+1])
    );
  end

  fpa_round #(.FRAC_BITS(FRAC_BITS)) u_round (
    .clk(clk), .rst(rst), .up_valid(v[NumCells]), .up_data(w[NumCells]),
    .out_stall(out_stall), .open(op[NumCells]), .out_valid(out_valid), .out_data(out_data)
  );
endmodule
`default_nettype wire

### rtl/fpa_checker.sv
`default_nettype none
module fpa_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fpa_pkg::out_word_t out_data
);
  import fpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_flag_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.flag |-> out_data.result == 32'sd0 && !out_data.overflow
      && !out_data.div_zero)
    else $error("comparison word carries a result or other flags");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.div_zero |-> !out_data.overflow)
    else $error("division by zero also marked as overflow");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |-> out_data.result == Max32 || out_data.result == Min32)
    else $error("overflow without a saturated result");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
